[rtl/circle_fan_vertex_generator_macros.svh]
// assertion macros for the checker file
`ifndef CIRCLE_FAN_VERTEX_GENERATOR_MACROS_SVH
`define CIRCLE_FAN_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CFVG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfvg same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define CFVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfvg next-cycle check failed");

`endif

[rtl/cfvg_pkg.sv]
// ----------------------------------------------------------------------------
// cfvg_pkg
// shared constants, types and the cordic arctangent table for the
// circle fan vertex generator
// ----------------------------------------------------------------------------
package cfvg_pkg;

   // field widths
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int FAN_W    = 6;

   // fan count ceiling
   localparam logic [FAN_W-1:0] MAX_FANS = 6'd63;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int ATAN_IDX_W   = 5;
   localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);
   localparam logic signed [COORD_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [COORD_W-1:0] ONE_Q30     = 32'sd1073741824;
   localparam logic signed [COORD_W-1:0] MINUS_ONE_Q30 = -32'sd1073741824;

   // phase divider: 2^32 / n, one quotient bit per cycle
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_MSB = 6'd32;

   // rounding bias for the q30 product
   localparam logic signed [63:0] ROUND_Q30 = 64'sd536870912;

   // cordic result handed to the sequencer
   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] cos_val;
      logic signed [COORD_W-1:0] sin_val;
   } cfvg_trig_type;

   // atan(2^-i) in turn units scaled by 2^32
   function automatic logic signed [COORD_W-1:0] atan_turn(
      input logic [ATAN_IDX_W-1:0] idx
   );
      logic signed [COORD_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'sd536870912;
         5'd1:  val = 32'sd316933406;
         5'd2:  val = 32'sd167458907;
         5'd3:  val = 32'sd85004756;
         5'd4:  val = 32'sd42667331;
         5'd5:  val = 32'sd21354465;
         5'd6:  val = 32'sd10679838;
         5'd7:  val = 32'sd5340245;
         5'd8:  val = 32'sd2670163;
         5'd9:  val = 32'sd1335087;
         5'd10: val = 32'sd667544;
         5'd11: val = 32'sd333772;
         5'd12: val = 32'sd166886;
         5'd13: val = 32'sd83443;
         5'd14: val = 32'sd41722;
         5'd15: val = 32'sd20861;
         5'd16: val = 32'sd10430;
         5'd17: val = 32'sd5215;
         5'd18: val = 32'sd2608;
         5'd19: val = 32'sd1304;
         5'd20: val = 32'sd652;
         5'd21: val = 32'sd326;
         5'd22: val = 32'sd163;
         5'd23: val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/cfvg_channels_if.sv]
// ----------------------------------------------------------------------------
// cfvg channels
// valid/ready channels for circle requests and vertex results
// ----------------------------------------------------------------------------
interface cfvg_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [cfvg_pkg::COORD_W-1:0]       center_x;
   logic signed [cfvg_pkg::COORD_W-1:0]       center_y;
   logic        [cfvg_pkg::RADIUS_W-1:0]      radius;
   logic        [cfvg_pkg::FAN_W-1:0]         fan_count;

   modport source (output valid, center_x, center_y, radius, fan_count, input ready);
   modport sink   (input valid, center_x, center_y, radius, fan_count, output ready);
endinterface

interface cfvg_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic        [cfvg_pkg::FAN_W-1:0]         vertex_number;
   logic signed [cfvg_pkg::COORD_W-1:0]       pos_x;
   logic signed [cfvg_pkg::COORD_W-1:0]       pos_y;
   logic                                      has_triangle;
   logic                                      tri_first;
   logic        [cfvg_pkg::FAN_W-1:0]         tri_second;
   logic        [cfvg_pkg::FAN_W-1:0]         tri_third;
   logic                                      last;

   modport source (output valid, vertex_number, pos_x, pos_y, has_triangle, tri_first,
                   tri_second, tri_third, last, input ready);
   modport sink   (input valid, vertex_number, pos_x, pos_y, has_triangle, tri_first,
                   tri_second, tri_third, last, output ready);
endinterface

[rtl/cfvg_cordic.sv]
// ----------------------------------------------------------------------------
// cfvg_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, followed by
// quadrant mapping and unit clamp
// ----------------------------------------------------------------------------
module cfvg_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cfvg_pkg::COORD_W-1:0]        phase,
   output cfvg_pkg::cfvg_trig_type             trig
);

   logic                                    run_ff, run_in;
   logic                                    fin_ff, fin_in;
   logic                                    done_ff, done_in;
   logic [cfvg_pkg::ATAN_IDX_W-1:0]         step_ff, step_in;
   logic signed [cfvg_pkg::COORD_W-1:0]     x_ff, x_in;
   logic signed [cfvg_pkg::COORD_W-1:0]     y_ff, y_in;
   logic signed [cfvg_pkg::COORD_W-1:0]     z_ff, z_in;
   logic [1:0]                              quad_ff, quad_in;
   logic signed [cfvg_pkg::COORD_W-1:0]     cos_ff, cos_in;
   logic signed [cfvg_pkg::COORD_W-1:0]     sin_ff, sin_in;

   logic signed [cfvg_pkg::COORD_W-1:0]     dx, dy, ang;
   logic signed [cfvg_pkg::COORD_W-1:0]     rot_c, rot_s;

   function automatic logic signed [cfvg_pkg::COORD_W-1:0] clamp_unit(
      input logic signed [cfvg_pkg::COORD_W-1:0] v
   );
      logic signed [cfvg_pkg::COORD_W-1:0] r;
      if (v > cfvg_pkg::ONE_Q30) begin
         r = cfvg_pkg::ONE_Q30;
      end else if (v < cfvg_pkg::MINUS_ONE_Q30) begin
         r = cfvg_pkg::MINUS_ONE_Q30;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // shared shifter and adders
   assign dx  = y_ff >>> step_ff;
   assign dy  = x_ff >>> step_ff;
   assign ang = cfvg_pkg::atan_turn(step_ff);

   // quadrant mapping
   always_comb begin
      case (quad_ff)
         2'd0: begin
            rot_c = x_ff;
            rot_s = y_ff;
         end
         2'd1: begin
            rot_c = -y_ff;
            rot_s = x_ff;
         end
         2'd2: begin
            rot_c = -x_ff;
            rot_s = -y_ff;
         end
         default: begin
            rot_c = y_ff;
            rot_s = -x_ff;
         end
      endcase
   end

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         x_in    = cfvg_pkg::CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({2'b00, phase[cfvg_pkg::COORD_W-3:0]});
         quad_in = phase[cfvg_pkg::COORD_W-1:cfvg_pkg::COORD_W-2];
      end else if (run_ff) begin
         if (!z_ff[cfvg_pkg::COORD_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == cfvg_pkg::LAST_STEP) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = clamp_unit(rot_c);
         sin_in  = clamp_unit(rot_s);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign trig.done    = done_ff;
   assign trig.cos_val = cos_ff;
   assign trig.sin_val = sin_ff;

endmodule

[rtl/circle_fan_vertex_generator.sv]
// ----------------------------------------------------------------------------
// circle_fan_vertex_generator
// triangle-fan tessellation of a circle into a stream of vertices
// ----------------------------------------------------------------------------
// One request (centre, radius, fan count n, saturated at 63) produces the
// centre vertex and then rim vertices 1..n, each with its triangle triple
// (0, k, k mod n + 1); the final vertex carries last. Requests are handled one
// at a time and req ready is low from the request transfer until the last
// vertex sits in the output register. The centre vertex goes out first, then
// the 2^32/n phase step divider runs (one quotient bit per cycle); each rim
// vertex then takes the 16 micro-rotations of the shared cordic plus the
// shared multiplier path (multiply, round, add-and-saturate for x then y).
// A zero fan count returns only the centre vertex.
module circle_fan_vertex_generator (
   input  logic        clock,
   input  logic        reset,
   cfvg_req_if.sink    req_ch,
   cfvg_rsp_if.source  rsp_ch
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_CENTER    = 9'b000000010,
      ST_DIV       = 9'b000000100,
      ST_TRIG_GO   = 9'b000001000,
      ST_TRIG_WAIT = 9'b000010000,
      ST_MUL       = 9'b000100000,
      ST_RND       = 9'b001000000,
      ST_ADD       = 9'b010000000,
      ST_EMIT      = 9'b100000000
   } state_type;

   localparam int CW = cfvg_pkg::COORD_W;
   localparam int FW = cfvg_pkg::FAN_W;

   state_type state_ff, state_in;

   // latched request
   logic signed [CW-1:0]                 cx_ff, cy_ff;
   logic [cfvg_pkg::RADIUS_W-1:0]        radius_ff;
   logic [FW-1:0]                        fans_ff;
   logic [FW-1:0]                        fans_sat;

   // phase step divider and accumulator
   logic [cfvg_pkg::DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [FW-1:0]                        rem_ff, rem_in;
   logic [CW-1:0]                        step_q_ff, step_q_in;
   logic [FW-1:0]                        step_r_ff, step_r_in;
   logic [CW-1:0]                        phase_ff, phase_in;
   logic [FW-1:0]                        frac_ff, frac_in;
   logic [FW-1:0]                        k_ff, k_in;
   logic [FW:0]                          trial;
   logic                                 trial_ge;
   logic [FW:0]                          frac_sum;
   logic                                 frac_carry;

   // shared multiply / round / saturate path
   logic                                 axis_ff, axis_in;
   logic signed [63:0]                   prod_ff, prod_in;
   logic signed [CW:0]                   off_ff, off_in;
   logic signed [63:0]                   rnd;
   logic signed [CW-1:0]                 rad_s;
   logic signed [CW-1:0]                 trig_sel;
   logic signed [CW-1:0]                 cent_sel;
   logic signed [CW+1:0]                 sum;
   logic signed [CW-1:0]                 sat_sum;
   logic signed [CW-1:0]                 posx_ff, posx_in;
   logic signed [CW-1:0]                 posy_ff, posy_in;

   // cordic handshake
   logic                                 trig_start;
   cfvg_pkg::cfvg_trig_type              trig;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                        out_vnum_ff;
   logic signed [CW-1:0]                 out_x_ff, out_y_ff;
   logic                                 out_tri_ff;
   logic [FW-1:0]                        out_second_ff, out_third_ff;
   logic                                 out_last_ff;
   logic                                 out_free;
   logic                                 load_center, load_rim;
   logic                                 req_xfer;
   logic                                 rim_last;

   cfvg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .phase (phase_ff),
      .trig  (trig)
   );

   // requests only in idle, never while reset is held
   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign fans_sat     = (req_ch.fan_count > cfvg_pkg::MAX_FANS) ? cfvg_pkg::MAX_FANS
                                                                 : req_ch.fan_count;

   // output register frees up when empty or being taken
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign load_center = (state_ff == ST_CENTER) && out_free;
   assign load_rim    = (state_ff == ST_EMIT) && out_free;
   assign rim_last    = (k_ff == fans_ff);

   // restoring divide of 2^32 by n: dividend bit is one only at the msb
   assign trial    = {rem_ff, (div_cnt_ff == cfvg_pkg::DIV_MSB)};
   assign trial_ge = (trial >= {1'b0, fans_ff});

   // fractional carry of the k*2^32/n accumulation
   assign frac_sum   = {1'b0, frac_ff} + {1'b0, step_r_ff};
   assign frac_carry = (frac_sum >= {1'b0, fans_ff});

   // multiplier operands
   assign rad_s    = $signed({1'b0, radius_ff});
   assign trig_sel = axis_ff ? trig.sin_val : trig.cos_val;
   assign cent_sel = axis_ff ? cy_ff : cx_ff;
   assign prod_in  = rad_s * trig_sel;
   assign rnd      = prod_ff + cfvg_pkg::ROUND_Q30;
   assign off_in   = rnd[62:30];

   // centre plus offset, saturated to 32 bits
   assign sum = {off_ff[CW], off_ff} + {{2{cent_sel[CW-1]}}, cent_sel};
   always_comb begin
      if (!sum[CW+1] && (sum[CW:CW-1] != 2'b00)) begin
         sat_sum = {1'b0, {(CW-1){1'b1}}};
      end else if (sum[CW+1] && (sum[CW:CW-1] != 2'b11)) begin
         sat_sum = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sat_sum = sum[CW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      rem_in     = rem_ff;
      step_q_in  = step_q_ff;
      step_r_in  = step_r_ff;
      phase_in   = phase_ff;
      frac_in    = frac_ff;
      k_in       = k_ff;
      axis_in    = axis_ff;
      posx_in    = posx_ff;
      posy_in    = posy_ff;
      trig_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            if (out_free) begin
               // zero fans: the centre vertex is the whole answer
               if (fans_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in   = ST_DIV;
                  div_cnt_in = cfvg_pkg::DIV_MSB;
                  rem_in     = '0;
                  step_q_in  = '0;
               end
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? FW'(trial - {1'b0, fans_ff}) : trial[FW-1:0];
            step_q_in  = {step_q_ff[CW-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               // phase of vertex 1 is the quotient itself
               step_r_in = rem_in;
               frac_in   = rem_in;
               phase_in  = step_q_in;
               k_in      = FW'(1);
               state_in  = ST_TRIG_GO;
            end
         end
         ST_TRIG_GO: begin
            trig_start = 1'b1;
            state_in   = ST_TRIG_WAIT;
         end
         ST_TRIG_WAIT: begin
            if (trig.done) begin
               axis_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (!axis_ff) begin
               posx_in  = sat_sum;
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               posy_in  = sat_sum;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (rim_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  frac_in  = frac_carry ? FW'(frac_sum - {1'b0, fans_ff})
                                        : frac_sum[FW-1:0];
                  phase_in = phase_ff + step_q_ff + {{(CW-1){1'b0}}, frac_carry};
                  state_in = ST_TRIG_GO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid: set on load, cleared on transfer
   always_comb begin
      if (load_center || load_rim) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
      rem_ff     <= rem_in;
      step_q_ff  <= step_q_in;
      step_r_ff  <= step_r_in;
      phase_ff   <= phase_in;
      frac_ff    <= frac_in;
      k_ff       <= k_in;
      axis_ff    <= axis_in;
      posx_ff    <= posx_in;
      posy_ff    <= posy_in;
      prod_ff    <= prod_in;
      off_ff     <= off_in;
   end

   // request latch
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cx_ff     <= req_ch.center_x;
         cy_ff     <= req_ch.center_y;
         radius_ff <= req_ch.radius;
         fans_ff   <= fans_sat;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load_center) begin
         out_vnum_ff   <= '0;
         out_x_ff      <= cx_ff;
         out_y_ff      <= cy_ff;
         out_tri_ff    <= 1'b0;
         out_second_ff <= '0;
         out_third_ff  <= '0;
         out_last_ff   <= (fans_ff == '0);
      end else if (load_rim) begin
         out_vnum_ff   <= k_ff;
         out_x_ff      <= posx_ff;
         out_y_ff      <= posy_ff;
         out_tri_ff    <= 1'b1;
         out_second_ff <= k_ff;
         out_third_ff  <= rim_last ? FW'(1) : (k_ff + 1'b1);
         out_last_ff   <= rim_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.vertex_number = out_vnum_ff;
   assign rsp_ch.pos_x         = out_x_ff;
   assign rsp_ch.pos_y         = out_y_ff;
   assign rsp_ch.has_triangle  = out_tri_ff;
   assign rsp_ch.tri_first     = 1'b0;
   assign rsp_ch.tri_second    = out_second_ff;
   assign rsp_ch.tri_third     = out_third_ff;
   assign rsp_ch.last          = out_last_ff;

endmodule

[rtl/cfvg_checker.sv]
// ----------------------------------------------------------------------------
// cfvg_checker
// port-level checks on request acceptance and vertex stream contents
// ----------------------------------------------------------------------------
`include "circle_fan_vertex_generator_macros.svh"

module cfvg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic [cfvg_pkg::FAN_W-1:0]         rsp_vertex_number,
   input logic                               rsp_has_triangle,
   input logic [cfvg_pkg::FAN_W-1:0]         rsp_tri_second,
   input logic [cfvg_pkg::FAN_W-1:0]         rsp_tri_third,
   input logic                               rsp_last
);

   // a request keeps the block busy for at least the next cycle
   `CFVG_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // while a new request can be taken, only a final vertex may still wait
   `CFVG_ASSERT_SAME(a_idle_only_last, clock, reset, rsp_valid && req_ready, rsp_last)

   // the centre vertex carries no triangle
   `CFVG_ASSERT_SAME(a_center_no_tri, clock, reset,
      rsp_valid && (rsp_vertex_number == '0),
      !rsp_has_triangle && (rsp_tri_second == '0) && (rsp_tri_third == '0))

   // rim vertex triangles point at the vertex itself and a nonzero neighbor
   `CFVG_ASSERT_SAME(a_rim_tri, clock, reset, rsp_valid && rsp_has_triangle,
      (rsp_tri_second == rsp_vertex_number) && (rsp_vertex_number != '0) &&
      (rsp_tri_third != '0))

endmodule

bind circle_fan_vertex_generator cfvg_checker u_cfvg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_vertex_number (rsp_ch.vertex_number),
   .rsp_has_triangle  (rsp_ch.has_triangle),
   .rsp_tri_second    (rsp_ch.tri_second),
   .rsp_tri_third     (rsp_ch.tri_third),
   .rsp_last          (rsp_ch.last)
);
